// ===== sv/ale_pkg.sv =====
// Shared field widths, command codes and status codes of the list engine.
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

  localparam int CMD_W  = 4;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 6;
  localparam int TOT_W  = 48;
  localparam int CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 4'd0,
    CMD_INSERT  = 4'd1,
    CMD_DELETE  = 4'd2,
    CMD_GET     = 4'd3,
    CMD_SET     = 4'd4,
    CMD_LSEARCH = 4'd5,
    CMD_BSEARCH = 4'd6,
    CMD_MIN     = 4'd7,
    CMD_MAX     = 4'd8,
    CMD_SUM     = 4'd9
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ===== sv/ale_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/array_list_engine_unit.sv =====
// Packed list engine: element memory, fill count and the command sequencer.
//
// One request on the input channel carries a command, a position and an operand.
// The request is taken while the sequencer is idle (in_stall_o low); exactly one
// response follows on the output channel with status, value, index, total and
// the element count after the command.
// Append, set and rejected commands finish in S_EXEC and go on to S_RESP; get
// reads in S_EXEC and takes the element in S_GET. Insert and delete shift the
// elements above the position, linear search, min, max and sum scan from the
// first element, and binary search alternates S_BS_RD and S_BS_CMP. The pace
// is set by the element memory, which gives one read and one write per cycle,
// so shifts and scans walk one element per cycle.
// A new request is taken the cycle after the previous result moves to the output
// register, so the sequencer works on one request at a time.
// The response sits in an output register; while the receiver stalls it holds
// still, and the next request can be taken and worked on meanwhile. A finished
// result waits in the sequencer until the output register is free.
// Reset empties the list (count zero) and drops any pending response. The
// memory itself is not cleared; only entries below the count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine_unit #(
  parameter int CAPACITY = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ale_pkg::CMD_W-1:0]      command_i,
  input  wire logic [ale_pkg::POS_W-1:0]      position_i,
  input  wire logic signed [ale_pkg::VAL_W-1:0] operand_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [ale_pkg::STAT_W-1:0]          status_o,
  output logic signed [ale_pkg::VAL_W-1:0]    result_value_o,
  output logic [ale_pkg::IDX_W-1:0]           result_index_o,
  output logic signed [ale_pkg::TOT_W-1:0]    total_o,
  output logic [ale_pkg::CNT_W-1:0]           element_count_o
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ale_pkg::POS_W) ? CW : ale_pkg::POS_W;
  localparam int VW   = ale_pkg::VAL_W;
  localparam int TW   = ale_pkg::TOT_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_INS     = 4'd2;
  localparam logic [3:0] S_INS_FIN = 4'd3;
  localparam logic [3:0] S_DEL0    = 4'd4;
  localparam logic [3:0] S_DEL     = 4'd5;
  localparam logic [3:0] S_GET     = 4'd6;
  localparam logic [3:0] S_SCAN    = 4'd7;
  localparam logic [3:0] S_BS_RD   = 4'd8;
  localparam logic [3:0] S_BS_CMP  = 4'd9;
  localparam logic [3:0] S_RESP    = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW:0] lo_q, lo_d, hi_q, hi_d;

  logic [ale_pkg::CMD_W-1:0] cmd_q;
  logic [ale_pkg::POS_W-1:0] pos_q;
  logic [VW-1:0] opv_q;

  logic [ale_pkg::STAT_W-1:0] res_status_q, res_status_d;
  logic [VW-1:0] res_value_q, res_value_d;
  logic [AW-1:0] res_index_q, res_index_d;
  logic [TW-1:0] res_total_q, res_total_d;

  logic out_valid_q;
  logic out_load;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;

  logic [CMPW-1:0] pos_x, cnt_x;
  logic [CW-1:0] ptr_next;
  logic ptr_more;
  logic is_full, is_empty;
  logic [CW:0] bs_sum;
  logic [CW-1:0] bs_mid;

  ale_ram #(
    .WIDTH(VW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign pos_x    = CMPW'(pos_q);
  assign cnt_x    = CMPW'(cnt_q);
  assign is_full  = (cnt_q == CW'(CAPACITY));
  assign is_empty = (cnt_q == '0);
  assign ptr_next = CW'(ptr_q) + CW'(1);
  assign ptr_more = (ptr_next < cnt_q);
  // Both bounds are non-negative whenever the search loop still runs.
  assign bs_sum   = {1'b0, lo_q[CW-1:0]} + {1'b0, hi_q[CW-1:0]};
  assign bs_mid   = bs_sum[CW:1];
  assign out_load = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_index_d  = res_index_q;
    res_total_d  = res_total_q;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q;
    ram_wdata    = opv_q;
    ram_raddr    = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = ale_pkg::ST_OK;
        res_value_d  = '0;
        res_index_d  = '0;
        res_total_d  = '0;
        state_d      = S_RESP;
        case (cmd_q)
          ale_pkg::CMD_APPEND: begin
            if (is_full) begin
              res_status_d = ale_pkg::ST_FULL;
            end else begin
              ram_we      = 1'b1;
              ram_waddr   = AW'(cnt_q);
              cnt_d       = cnt_q + CW'(1);
              res_value_d = opv_q;
            end
          end
          ale_pkg::CMD_INSERT: begin
            if (is_full) begin
              res_status_d = ale_pkg::ST_FULL;
            end else if (pos_x > cnt_x) begin
              res_status_d = ale_pkg::ST_BAD_POS;
            end else if (pos_x == cnt_x) begin
              ram_we      = 1'b1;
              ram_waddr   = AW'(pos_q);
              cnt_d       = cnt_q + CW'(1);
              res_value_d = opv_q;
            end else begin
              // Shift up from the top element down to the insert position.
              ram_raddr = AW'(cnt_q - CW'(1));
              ptr_d     = AW'(cnt_q - CW'(1));
              state_d   = S_INS;
            end
          end
          ale_pkg::CMD_DELETE: begin
            if (pos_x >= cnt_x) begin
              res_status_d = ale_pkg::ST_BAD_POS;
            end else begin
              ram_raddr = AW'(pos_q);
              ptr_d     = AW'(pos_q);
              state_d   = S_DEL0;
            end
          end
          ale_pkg::CMD_GET: begin
            if (pos_x >= cnt_x) begin
              res_status_d = ale_pkg::ST_BAD_POS;
            end else begin
              ram_raddr = AW'(pos_q);
              state_d   = S_GET;
            end
          end
          ale_pkg::CMD_SET: begin
            if (pos_x >= cnt_x) begin
              res_status_d = ale_pkg::ST_BAD_POS;
            end else begin
              ram_we      = 1'b1;
              ram_waddr   = AW'(pos_q);
              res_value_d = opv_q;
            end
          end
          ale_pkg::CMD_LSEARCH, ale_pkg::CMD_MIN, ale_pkg::CMD_MAX,
          ale_pkg::CMD_SUM: begin
            if (is_empty) begin
              res_status_d = ale_pkg::ST_EMPTY;
            end else begin
              ram_raddr = '0;
              ptr_d     = '0;
              state_d   = S_SCAN;
            end
          end
          ale_pkg::CMD_BSEARCH: begin
            if (is_empty) begin
              res_status_d = ale_pkg::ST_EMPTY;
            end else begin
              lo_d    = '0;
              hi_d    = (CW+1)'(cnt_q) - (CW+1)'(1);
              state_d = S_BS_RD;
            end
          end
          default: begin
          end
        endcase
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_q == AW'(pos_q)) begin
          state_d = S_INS_FIN;
        end else begin
          ram_raddr = ptr_q - AW'(1);
          ptr_d     = ptr_q - AW'(1);
        end
      end

      S_INS_FIN: begin
        ram_we      = 1'b1;
        ram_waddr   = AW'(pos_q);
        cnt_d       = cnt_q + CW'(1);
        res_value_d = opv_q;
        state_d     = S_RESP;
      end

      S_DEL0: begin
        res_value_d = ram_rdata;
        if (ptr_more) begin
          ram_raddr = AW'(ptr_next);
          ptr_d     = AW'(ptr_next);
          state_d   = S_DEL;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_RESP;
        end
      end

      S_DEL: begin
        // The element read last cycle moves down by one place.
        ram_we    = 1'b1;
        ram_waddr = ptr_q - AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_more) begin
          ram_raddr = AW'(ptr_next);
          ptr_d     = AW'(ptr_next);
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_RESP;
        end
      end

      S_GET: begin
        res_value_d = ram_rdata;
        state_d     = S_RESP;
      end

      S_SCAN: begin
        ram_raddr = AW'(ptr_next);
        ptr_d     = AW'(ptr_next);
        if (!ptr_more) begin
          state_d = S_RESP;
        end
        case (cmd_q)
          ale_pkg::CMD_LSEARCH: begin
            if (ram_rdata == opv_q) begin
              res_index_d = ptr_q;
              state_d     = S_RESP;
            end else if (!ptr_more) begin
              res_status_d = ale_pkg::ST_NOT_FOUND;
            end
          end
          ale_pkg::CMD_MIN: begin
            if (ptr_q == '0 || $signed(ram_rdata) < $signed(res_value_q)) begin
              res_value_d = ram_rdata;
            end
          end
          ale_pkg::CMD_MAX: begin
            if (ptr_q == '0 || $signed(res_value_q) < $signed(ram_rdata)) begin
              res_value_d = ram_rdata;
            end
          end
          default: begin
            res_total_d = res_total_q + {{(TW-VW){ram_rdata[VW-1]}}, ram_rdata};
          end
        endcase
      end

      S_BS_RD: begin
        if ($signed(lo_q) <= $signed(hi_q)) begin
          ram_raddr = AW'(bs_mid);
          ptr_d     = AW'(bs_mid);
          state_d   = S_BS_CMP;
        end else begin
          res_status_d = ale_pkg::ST_NOT_FOUND;
          state_d      = S_RESP;
        end
      end

      S_BS_CMP: begin
        if (ram_rdata == opv_q) begin
          res_index_d = ptr_q;
          state_d     = S_RESP;
        end else if ($signed(ram_rdata) < $signed(opv_q)) begin
          lo_d    = (CW+1)'(ptr_q) + (CW+1)'(1);
          state_d = S_BS_RD;
        end else begin
          hi_d    = (CW+1)'(ptr_q) - (CW+1)'(1);
          state_d = S_BS_RD;
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_index_q  <= res_index_d;
    res_total_q  <= res_total_d;
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q <= command_i;
      pos_q <= position_i;
      opv_q <= operand_value_i;
    end
    if (out_load) begin
      status_o        <= res_status_q;
      result_value_o  <= res_value_q;
      result_index_o  <= ale_pkg::IDX_W'(res_index_q);
      total_o         <= res_total_q;
      element_count_o <= ale_pkg::CNT_W'(cnt_q);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CW'(1) ||
    cnt_q == $past(cnt_q) - CW'(1))
    else $error("element count moved by more than one");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != S_IDLE && state_q != S_RESP))
    else $error("memory written outside command execution");

  a_resp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("response raised without a finished command");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the packed list engine: directed and random commands.
`timescale 1ns / 1ps

module tb;

  localparam int LIST_CAP = 64;
  localparam int MAX_GAP = 14;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct {
    logic [ale_pkg::CMD_W-1:0]        cmd;
    logic [ale_pkg::POS_W-1:0]        pos;
    logic signed [ale_pkg::VAL_W-1:0] val;
    int                               gap;
  } list_req_t;

  typedef struct {
    logic [ale_pkg::STAT_W-1:0]       status;
    logic signed [ale_pkg::VAL_W-1:0] value;
    logic [ale_pkg::IDX_W-1:0]        index;
    logic signed [ale_pkg::TOT_W-1:0] total;
    logic [ale_pkg::CNT_W-1:0]        count;
  } list_resp_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic [ale_pkg::CMD_W-1:0]        command_i = '0;
  logic [ale_pkg::POS_W-1:0]        position_i = '0;
  logic signed [ale_pkg::VAL_W-1:0] operand_value_i = '0;
  logic                             out_stall_i = 1'b0;
  logic                             in_stall_o;
  logic                             out_valid_o;
  logic [ale_pkg::STAT_W-1:0]       status_o;
  logic signed [ale_pkg::VAL_W-1:0] result_value_o;
  logic [ale_pkg::IDX_W-1:0]        result_index_o;
  logic signed [ale_pkg::TOT_W-1:0] total_o;
  logic [ale_pkg::CNT_W-1:0]        element_count_o;

  list_req_t  pending_reqs[$];
  list_resp_t expected_resps[$];

  // Predicted list contents and fill count.
  logic signed [ale_pkg::VAL_W-1:0] list_mem [LIST_CAP];
  int list_len = 0;

  int errors = 0;
  bit burst = 1'b0;

  always #2 clk_i = ~clk_i;

  array_list_engine_unit #(.CAPACITY(LIST_CAP)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .position_i      (position_i),
    .operand_value_i (operand_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .result_value_o  (result_value_o),
    .result_index_o  (result_index_o),
    .total_o         (total_o),
    .element_count_o (element_count_o)
  );

  // Runs one command on the predicted list and returns the response it should produce.
  function automatic list_resp_t list_apply(input logic [ale_pkg::CMD_W-1:0] cmd,
                                            input logic [ale_pkg::POS_W-1:0] pos,
                                            input logic signed [ale_pkg::VAL_W-1:0] val);
    list_resp_t r;
    int i, lo, hi, mid;
    logic signed [ale_pkg::TOT_W-1:0] acc;
    r.status = ale_pkg::ST_OK;
    r.value = '0;
    r.index = '0;
    r.total = '0;
    case (ale_pkg::cmd_e'(cmd))
      ale_pkg::CMD_APPEND: begin
        if (list_len >= LIST_CAP) begin
          r.status = ale_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
          r.value = val;
        end
      end
      ale_pkg::CMD_INSERT: begin
        // A full store is reported ahead of a bad position.
        if (list_len >= LIST_CAP) begin
          r.status = ale_pkg::ST_FULL;
        end else if (pos > list_len) begin
          r.status = ale_pkg::ST_BAD_POS;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
          r.value = val;
        end
      end
      ale_pkg::CMD_DELETE: begin
        if (pos >= list_len) begin
          r.status = ale_pkg::ST_BAD_POS;
        end else begin
          r.value = list_mem[pos];
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ale_pkg::CMD_GET: begin
        if (pos >= list_len) r.status = ale_pkg::ST_BAD_POS;
        else r.value = list_mem[pos];
      end
      ale_pkg::CMD_SET: begin
        if (pos >= list_len) begin
          r.status = ale_pkg::ST_BAD_POS;
        end else begin
          list_mem[pos] = val;
          r.value = val;
        end
      end
      ale_pkg::CMD_LSEARCH: begin
        if (list_len == 0) begin
          r.status = ale_pkg::ST_EMPTY;
        end else begin
          r.status = ale_pkg::ST_NOT_FOUND;
          for (i = 0; i < list_len; i++) begin
            if (list_mem[i] == val) begin
              r.status = ale_pkg::ST_OK;
              r.index = i[ale_pkg::IDX_W-1:0];
              break;
            end
          end
        end
      end
      ale_pkg::CMD_BSEARCH: begin
        if (list_len == 0) begin
          r.status = ale_pkg::ST_EMPTY;
        end else begin
          r.status = ale_pkg::ST_NOT_FOUND;
          lo = 0;
          hi = list_len - 1;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (list_mem[mid] == val) begin
              r.status = ale_pkg::ST_OK;
              r.index = mid[ale_pkg::IDX_W-1:0];
              break;
            end else if (list_mem[mid] < val) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
        end
      end
      ale_pkg::CMD_MIN, ale_pkg::CMD_MAX: begin
        if (list_len == 0) begin
          r.status = ale_pkg::ST_EMPTY;
        end else begin
          r.value = list_mem[0];
          for (i = 1; i < list_len; i++) begin
            if (cmd == ale_pkg::CMD_MIN ? list_mem[i] < r.value : list_mem[i] > r.value)
              r.value = list_mem[i];
          end
        end
      end
      ale_pkg::CMD_SUM: begin
        if (list_len == 0) begin
          r.status = ale_pkg::ST_EMPTY;
        end else begin
          acc = '0;
          for (i = 0; i < list_len; i++) acc = acc + list_mem[i];
          r.total = acc;
        end
      end
      default: ;
    endcase
    r.count = list_len[ale_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want_v,
                                      input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  function automatic logic signed [ale_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r < 4) return int'($urandom_range(0, 8)) - 4;
    case (r)
      4: return 32'sh7fff_ffff;
      5: return 32'sh8000_0000;
      6: return 32'sd0;
      7: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_req(input logic [ale_pkg::CMD_W-1:0] cmd, input int pos,
                           input logic signed [ale_pkg::VAL_W-1:0] val);
    list_req_t r;
    r.cmd = cmd;
    r.pos = pos[ale_pkg::POS_W-1:0];
    r.val = val;
    r.gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    pending_reqs.push_back(r);
  endtask

  // Deleting at the head once per slot always leaves the list empty.
  task automatic clear_list();
    repeat (LIST_CAP) queue_req(ale_pkg::CMD_DELETE, 0, pick_value());
  endtask

  // Request driver: waits the drawn gap, then holds each request until it is taken.
  int gap_left = 0;
  bit gap_armed = 1'b0;
  list_req_t next_req;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        expected_resps.push_back(list_apply(command_i, position_i, operand_value_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          if (!gap_armed) begin
            gap_left = pending_reqs[0].gap;
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
            in_valid_i <= 1'b0;
          end else begin
            next_req = pending_reqs.pop_front();
            gap_armed = 1'b0;
            in_valid_i <= 1'b1;
            command_i <= next_req.cmd;
            position_i <= next_req.pos;
            operand_value_i <= next_req.val;
          end
        end
      end
    end
  end

  // One long hold-off on the output, counted here, lets the engine back up and stall its input.
  int hold_left = 0;
  int hold_seen = 0;
  bit held = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) hold_seen++;
      if (!held && hold_seen == 300) begin
        hold_left <= 600;
        held = 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Response monitor: checks each response and stalls a drawn number of cycles per response.
  int stall_left = 0;
  bit calm = 1'b0;
  list_resp_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: response with no request outstanding, expected none, got status %0d",
                   $time, status_o);
          errors++;
        end else begin
          want = expected_resps.pop_front();
          check_field("status", want.status, status_o);
          check_field("result_value", want.value, result_value_o);
          check_field("result_index", want.index, result_index_o);
          check_field("total", want.total, total_o);
          check_field("element_count", want.count, element_count_o);
        end
        stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 39) == 0) calm = !calm;
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (hold_left > 0) || (stall_left > 0);
    end
  end

  initial begin : stimulus
    int n, k, r, kind, pattern;
    longint step, base, span, key;

    // Empty list: every command that needs contents is refused.
    queue_req(ale_pkg::CMD_SUM, 0, 0);
    queue_req(ale_pkg::CMD_MIN, 0, 0);
    queue_req(ale_pkg::CMD_MAX, 0, 0);
    queue_req(ale_pkg::CMD_LSEARCH, 0, 0);
    queue_req(ale_pkg::CMD_BSEARCH, 0, 0);
    queue_req(ale_pkg::CMD_DELETE, 0, 0);
    queue_req(ale_pkg::CMD_GET, 0, 0);
    queue_req(ale_pkg::CMD_SET, 0, 1);
    queue_req(ale_pkg::CMD_INSERT, 1, 1);
    // Build a short list from the value extremes.
    queue_req(ale_pkg::CMD_INSERT, 0, 32'sh7fff_ffff);
    queue_req(ale_pkg::CMD_APPEND, 0, 32'sh8000_0000);
    queue_req(ale_pkg::CMD_INSERT, 1, -32'sd1);
    queue_req(ale_pkg::CMD_APPEND, 0, 0);
    queue_req(ale_pkg::CMD_GET, 3, 0);
    queue_req(ale_pkg::CMD_GET, 4, 0);
    queue_req(ale_pkg::CMD_SET, 2, 5);
    queue_req(ale_pkg::CMD_LSEARCH, 0, 5);
    queue_req(ale_pkg::CMD_LSEARCH, 0, 7);
    queue_req(ale_pkg::CMD_BSEARCH, 0, -32'sd1);
    queue_req(ale_pkg::CMD_MIN, 0, 0);
    queue_req(ale_pkg::CMD_MAX, 0, 0);
    queue_req(ale_pkg::CMD_SUM, 0, 0);
    queue_req(ale_pkg::CMD_DELETE, 1, 0);
    queue_req(4'd15, 127, -32'sd1);
    queue_req(ale_pkg::CMD_INSERT, 127, 3);

    while (pending_reqs.size() < RANDOM_ITEMS + 25) begin
      burst = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 5);
      if (kind < 3) begin
        // Mixed traffic on whatever the list holds.
        repeat (30) begin
          r = $urandom_range(0, 99);
          k = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 48);
          if (r < 25) queue_req(ale_pkg::CMD_APPEND, k, pick_value());
          else if (r < 42) queue_req(ale_pkg::CMD_INSERT, k, pick_value());
          else if (r < 54) queue_req(ale_pkg::CMD_DELETE, k, pick_value());
          else if (r < 63) queue_req(ale_pkg::CMD_GET, k, pick_value());
          else if (r < 70) queue_req(ale_pkg::CMD_SET, k, pick_value());
          else if (r < 78) queue_req(ale_pkg::CMD_LSEARCH, k, pick_value());
          else if (r < 84) queue_req(ale_pkg::CMD_BSEARCH, k, pick_value());
          else if (r < 89) queue_req(ale_pkg::CMD_MIN, k, pick_value());
          else if (r < 94) queue_req(ale_pkg::CMD_MAX, k, pick_value());
          else if (r < 98) queue_req(ale_pkg::CMD_SUM, k, pick_value());
          else queue_req(4'($urandom_range(10, 15)), k, pick_value());
        end
      end else if (kind < 5) begin
        // Non-decreasing contents, then mostly binary searches for present and absent keys.
        clear_list();
        n = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, LIST_CAP);
        step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 60000000);
        span = 64'sd4294967295 - (n - 1) * step;
        base = -64'sd2147483648 + longint'($urandom_range(0, span));
        for (int i = 0; i < n; i++)
          queue_req(ale_pkg::CMD_APPEND, $urandom_range(0, 127), base + i * step);
        repeat (20) begin
          k = $urandom_range(0, n - 1);
          key = base + k * step;
          case ($urandom_range(0, 9))
            5: queue_req(ale_pkg::CMD_BSEARCH, k, key + 1);
            6: queue_req(ale_pkg::CMD_BSEARCH, k, key - 1);
            7: queue_req(ale_pkg::CMD_BSEARCH, k,
                         $urandom_range(0, 1) ? base - 1 : base + n * step);
            8: queue_req(ale_pkg::CMD_LSEARCH, k, key);
            9: begin
              r = $urandom_range(0, 3);
              if (r == 0) queue_req(ale_pkg::CMD_MIN, k, key);
              else if (r == 1) queue_req(ale_pkg::CMD_MAX, k, key);
              else if (r == 2) queue_req(ale_pkg::CMD_SUM, k, key);
              else queue_req(ale_pkg::CMD_GET, k, key);
            end
            default: queue_req(ale_pkg::CMD_BSEARCH, k, key);
          endcase
        end
      end else begin
        // Fill to capacity, hit the full store, then work on a full list.
        clear_list();
        pattern = $urandom_range(0, 2);
        repeat (LIST_CAP)
          queue_req(ale_pkg::CMD_APPEND, $urandom_range(0, 127),
                    pattern == 0 ? 32'sh7fff_ffff :
                    pattern == 1 ? 32'sh8000_0000 : pick_value());
        queue_req(ale_pkg::CMD_APPEND, 0, pick_value());
        queue_req(ale_pkg::CMD_INSERT, $urandom_range(0, 127), pick_value());
        queue_req(ale_pkg::CMD_SUM, 0, 0);
        queue_req(ale_pkg::CMD_MIN, 0, 0);
        queue_req(ale_pkg::CMD_MAX, 0, 0);
        key = $urandom();
        queue_req(ale_pkg::CMD_SET, LIST_CAP - 1, key);
        queue_req(ale_pkg::CMD_LSEARCH, 0, key);
        queue_req(ale_pkg::CMD_GET, LIST_CAP - 1, 0);
        repeat (20) begin
          k = $urandom_range(0, LIST_CAP);
          r = $urandom_range(0, 3);
          if (r == 0) queue_req(ale_pkg::CMD_DELETE, k, pick_value());
          else if (r == 1) queue_req(ale_pkg::CMD_INSERT, k, pick_value());
          else if (r == 2) queue_req(ale_pkg::CMD_SET, k, pick_value());
          else queue_req(ale_pkg::CMD_GET, k, pick_value());
        end
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_resps.size() != 0);
    repeat (100) @(posedge clk_i);

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
